// ===== sv/rrl_pkg.sv =====
// Shared types and constants for the rectangle region locator.
// Used by the controller, the datapath, the top level and the checker.
package rrl_pkg;

   localparam int MAX_REGIONS_DEFAULT = 8;

   localparam int FUNC_W  = 2;
   localparam int SLOT_W  = 3;
   localparam int POS_W   = 16;
   localparam int SIZE_W  = 15;
   localparam int COUNT_W = 4;
   localparam int INDEX_W = 3;
   localparam int ENTRY_W = 2 * POS_W + 2 * SIZE_W;

   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POINT  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WINDOW = 2'd2;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [SIZE_W-1:0]       w;
      logic [SIZE_W-1:0]       h;
   } region_type;

   typedef struct packed {
      logic write_en;
      logic load_query;
      logic rd_en;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic pipe_empty;
   } status_type;

endpackage

// ===== sv/rrl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rrl_ctrl.sv =====
// Controller of the rectangle region locator: accepts words, sequences the table scan.
// Depends on rrl_pkg.
module rrl_ctrl #(
   parameter int MAX_REGIONS = rrl_pkg::MAX_REGIONS_DEFAULT,
   localparam int AddrW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
   localparam int CntW = $clog2(MAX_REGIONS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rrl_pkg::FUNC_W-1:0]   req_func,
   input  logic [rrl_pkg::SLOT_W-1:0]   req_slot,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rrl_pkg::COUNT_W-1:0]  csr_region_count,
   output rrl_pkg::cmd_type             cmd,
   output logic [AddrW-1:0]             rd_addr,
   input  rrl_pkg::status_type          status
);
   import rrl_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CntW-1:0]    scan_ff, scan_in;
   logic [COUNT_W-1:0] count_ff;
   logic [CntW-1:0]    active;
   logic               accept;
   logic               is_query;
   int                 cnt_i;

   always_comb begin
      cnt_i = int'(count_ff);
      if (cnt_i > MAX_REGIONS) begin
         cnt_i = MAX_REGIONS;
      end
      active = CntW'(cnt_i);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign is_query  = (req_func == FUNC_POINT) || (req_func == FUNC_WINDOW);
   assign rd_addr   = scan_ff[AddrW-1:0];

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_LOAD) begin
                  cmd.write_en = (int'(req_slot) < MAX_REGIONS);
               end else if (is_query) begin
                  cmd.load_query = 1'b1;
                  scan_in        = '0;
                  state_in       = (active == '0) ? ST_DRAIN : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            scan_in   = scan_ff + 1'b1;
            if (scan_in == active) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_region_count;
         end
      end
   end

endmodule

// ===== sv/rrl_dp.sv =====
// Datapath of the rectangle region locator: region table, distance and overlap
// pipeline, and best-candidate tracking. Depends on rrl_pkg and rrl_ram.
module rrl_dp #(
   parameter int MAX_REGIONS = rrl_pkg::MAX_REGIONS_DEFAULT,
   localparam int AddrW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rrl_pkg::FUNC_W-1:0]        req_func,
   input  logic [rrl_pkg::SLOT_W-1:0]        req_slot,
   input  logic signed [rrl_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [rrl_pkg::POS_W-1:0]  req_pos_y,
   input  logic [rrl_pkg::SIZE_W-1:0]        req_size_w,
   input  logic [rrl_pkg::SIZE_W-1:0]        req_size_h,
   input  rrl_pkg::cmd_type                  cmd,
   input  logic [AddrW-1:0]                  rd_addr,
   output rrl_pkg::status_type               status,
   output logic                              rsp_valid,
   output logic [rrl_pkg::INDEX_W-1:0]       rsp_region_index
);
   import rrl_pkg::*;

   localparam int CW = POS_W + 2;
   localparam int DW = POS_W + 1;
   localparam int AW2 = 2 * SIZE_W;

   function automatic logic [DW-1:0] axis_dist(logic signed [CW-1:0] p,
                                               logic signed [CW-1:0] org,
                                               logic signed [CW-1:0] fin);
      logic signed [CW:0] d;
      begin
         if (p < org) begin
            d = {org[CW-1], org} - {p[CW-1], p};
         end else if (p >= fin) begin
            d = {p[CW-1], p} - {fin[CW-1], fin} + 1'b1;
         end else begin
            d = '0;
         end
         return d[DW-1:0];
      end
   endfunction

   function automatic logic [SIZE_W-1:0] overlap_len(logic signed [CW-1:0] a0,
                                                     logic signed [CW-1:0] a1,
                                                     logic signed [CW-1:0] b0,
                                                     logic signed [CW-1:0] b1);
      logic signed [CW-1:0] lo;
      logic signed [CW-1:0] hi;
      logic signed [CW:0]   diff;
      begin
         lo   = (a0 > b0) ? a0 : b0;
         hi   = (a1 < b1) ? a1 : b1;
         diff = {hi[CW-1], hi} - {lo[CW-1], lo};
         return (hi > lo) ? diff[SIZE_W-1:0] : '0;
      end
   endfunction

   region_type        wr_entry;
   region_type        rd_entry;
   logic [ENTRY_W-1:0] rd_word;
   logic [6:0]        slot_ext;

   logic signed [CW-1:0] qx_ff, qy_ff;
   logic signed [CW-1:0] wx_ff, wy_ff, wxe_ff, wye_ff;
   logic                 win_ff;

   logic                 v1_ff, v2_ff, v3_ff;
   logic [AddrW-1:0]     idx1_ff, idx2_ff, idx3_ff;
   logic [SIZE_W-1:0]    lenx_ff, leny_ff;
   logic [DW:0]          dist2_ff, dist3_ff;
   logic [AW2-1:0]       area3_ff;

   logic                 near_found_ff, area_found_ff;
   logic [DW:0]          near_d_ff;
   logic [AW2-1:0]       area_ff;
   logic [AddrW-1:0]     near_idx_ff, area_idx_ff;

   logic                 rsp_valid_ff;
   logic [INDEX_W-1:0]   rsp_idx_ff;
   logic [AddrW-1:0]     pick;
   logic [6:0]           pick_ext;

   logic signed [CW-1:0] rx, ry, rxe, rye;
   logic [DW:0]          dist_in;

   assign slot_ext   = {{(7 - SLOT_W){1'b0}}, req_slot};
   assign wr_entry.x = req_pos_x;
   assign wr_entry.y = req_pos_y;
   assign wr_entry.w = req_size_w;
   assign wr_entry.h = req_size_h;

   rrl_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_REGIONS)
   ) u_table (
      .clock  (clock),
      .wr_en  (cmd.write_en),
      .wr_addr(slot_ext[AddrW-1:0]),
      .wr_data(wr_entry),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_word)
   );

   assign rd_entry = rd_word;
   assign rx  = CW'(rd_entry.x);
   assign ry  = CW'(rd_entry.y);
   assign rxe = CW'(rd_entry.x) + $signed({3'b000, rd_entry.w});
   assign rye = CW'(rd_entry.y) + $signed({3'b000, rd_entry.h});
   assign dist_in = {1'b0, axis_dist(qx_ff, rx, rxe)} + {1'b0, axis_dist(qy_ff, ry, rye)};

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         win_ff <= (req_func == FUNC_WINDOW);
         wx_ff  <= CW'(req_pos_x);
         wy_ff  <= CW'(req_pos_y);
         wxe_ff <= CW'(req_pos_x) + $signed({3'b000, req_size_w});
         wye_ff <= CW'(req_pos_y) + $signed({3'b000, req_size_h});
         if (req_func == FUNC_WINDOW) begin
            qx_ff <= CW'(req_pos_x) + $signed({4'b0000, req_size_w[SIZE_W-1:1]});
            qy_ff <= CW'(req_pos_y) + $signed({4'b0000, req_size_h[SIZE_W-1:1]});
         end else begin
            qx_ff <= CW'(req_pos_x);
            qy_ff <= CW'(req_pos_y);
         end
      end
      idx1_ff  <= rd_addr;
      idx2_ff  <= idx1_ff;
      lenx_ff  <= overlap_len(wx_ff, wxe_ff, rx, rxe);
      leny_ff  <= overlap_len(wy_ff, wye_ff, ry, rye);
      dist2_ff <= dist_in;
      idx3_ff  <= idx2_ff;
      area3_ff <= lenx_ff * leny_ff;
      dist3_ff <= dist2_ff;
      if (v3_ff && (!near_found_ff || (dist3_ff < near_d_ff))) begin
         near_d_ff   <= dist3_ff;
         near_idx_ff <= idx3_ff;
      end
      if (v3_ff && (area3_ff > area_ff)) begin
         area_ff     <= area3_ff;
         area_idx_ff <= idx3_ff;
      end
      if (cmd.load_query) begin
         area_ff     <= '0;
         near_idx_ff <= '0;
         area_idx_ff <= '0;
      end
      if (cmd.finish) begin
         rsp_idx_ff <= pick_ext[INDEX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         near_found_ff <= 1'b0;
         area_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         v1_ff        <= cmd.rd_en;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= cmd.finish;
         if (cmd.load_query) begin
            near_found_ff <= 1'b0;
            area_found_ff <= 1'b0;
         end else if (v3_ff) begin
            near_found_ff <= 1'b1;
            if (area3_ff > area_ff) begin
               area_found_ff <= 1'b1;
            end
         end
      end
   end

   assign pick     = (win_ff && area_found_ff) ? area_idx_ff : near_idx_ff;
   assign pick_ext = 7'(pick);

   assign status.pipe_empty = !(v1_ff || v2_ff || v3_ff);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_region_index  = rsp_idx_ff;

endmodule

// ===== sv/rectangle_region_locator.sv =====
// Rectangle region locator: table of display rectangles with point and window lookup.
// Top level joining rrl_ctrl and rrl_dp; depends on rrl_pkg.
//
// A word is taken at a rising edge with start high and busy low. A load word
// (func 0) writes one table entry in that cycle and gives no result; busy stays
// low, so loads can follow back to back. A point or window query raises busy and
// scans the first region_count entries, one entry per cycle through the table's
// read port and a distance, overlap and area pipeline. Both the overlap area and
// the distance to the query point are tracked in the same pass. The scan covers
// region_count entries, capped at the table depth; a count of zero skips the scan.
// The controller waits for the pipeline to drain before showing the result, and
// busy falls in the cycle the result is shown. The result is on rsp_region_index
// for one cycle with rsp_valid high and must be taken then. The region_count
// register is written through csr_valid and csr_ready, which is always high;
// the user must write it only while the block is idle, as the block itself
// does not enforce this.
// Reset clears the control state and region_count; table entries hold
// nothing meaningful until loaded.
module rectangle_region_locator #(
   parameter int MAX_REGIONS = rrl_pkg::MAX_REGIONS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rrl_pkg::FUNC_W-1:0]        req_func,
   input  logic [rrl_pkg::SLOT_W-1:0]        req_slot,
   input  logic signed [rrl_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [rrl_pkg::POS_W-1:0]  req_pos_y,
   input  logic [rrl_pkg::SIZE_W-1:0]        req_size_w,
   input  logic [rrl_pkg::SIZE_W-1:0]        req_size_h,
   output logic                              rsp_valid,
   output logic [rrl_pkg::INDEX_W-1:0]       rsp_region_index,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rrl_pkg::COUNT_W-1:0]       csr_region_count
);
   import rrl_pkg::*;

   localparam int AddrW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

   cmd_type          cmd;
   status_type       status;
   logic [AddrW-1:0] rd_addr;

   rrl_ctrl #(
      .MAX_REGIONS(MAX_REGIONS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_slot        (req_slot),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_region_count(csr_region_count),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .status          (status)
   );

   rrl_dp #(
      .MAX_REGIONS(MAX_REGIONS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_slot        (req_slot),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_size_w      (req_size_w),
      .req_size_h      (req_size_h),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_region_index(rsp_region_index)
   );

endmodule

// ===== sv/rrl_checker.sv =====
// Port-level checks for the rectangle region locator, bound to the top level.
// Depends on rrl_pkg.
module rrl_checker #(
   parameter int MAX_REGIONS = rrl_pkg::MAX_REGIONS_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [rrl_pkg::FUNC_W-1:0]        req_func,
   input logic                              rsp_valid,
   input logic [rrl_pkg::INDEX_W-1:0]       rsp_region_index
);
   import rrl_pkg::*;

   logic query_accept;
   logic other_accept;

   assign query_accept = start && !busy &&
                         ((req_func == FUNC_POINT) || (req_func == FUNC_WINDOW));
   assign other_accept = start && !busy &&
                         (req_func != FUNC_POINT) && (req_func != FUNC_WINDOW);

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a query in progress");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      query_accept |=> busy && !rsp_valid)
      else $error("query accepted without going busy");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      other_accept |=> !busy && !rsp_valid)
      else $error("load word caused activity");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (MAX_REGIONS >= 8) || (int'(rsp_region_index) < MAX_REGIONS))
      else $error("result index beyond the table");

endmodule

bind rectangle_region_locator rrl_checker #(
   .MAX_REGIONS(MAX_REGIONS)
) u_rrl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_func        (req_func),
   .rsp_valid       (rsp_valid),
   .rsp_region_index(rsp_region_index)
);
